>>> rtl/tcp_handshake_conn_table_macros.svh
// Assertion macros used by the connection table checker.
`ifndef TCP_HANDSHAKE_CONN_TABLE_MACROS_SVH
`define TCP_HANDSHAKE_CONN_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TCP_HS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TCP_HS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tcp_hs_pkg.sv
// Shared types, constants and slot index table for the TCP handshake connection table.
package tcp_hs_pkg;

   localparam int SLOTS  = 256;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [1:0] {
      CS_IDLE     = 2'd0,
      CS_SYN_SENT = 2'd1,
      CS_SYN_RECV = 2'd2,
      CS_ESTAB    = 2'd3
   } hs_state_type;

   typedef enum logic [1:0] {
      RC_NONE      = 2'd0,
      RC_ESTAB     = 2'd1,
      RC_HANDSHAKE = 2'd2
   } reset_class_type;

   typedef enum logic {
      OP_SEGMENT = 1'b0,
      OP_WRITE   = 1'b1
   } op_type;

   // one slot record as kept in the table RAM
   typedef struct packed {
      logic [1:0]  state;
      logic [31:0] local_seq;
      logic [31:0] peer_ack_seq;
   } rec_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  slot;
      logic        flag_syn;
      logic        flag_ack;
      logic        flag_rst;
      logic [31:0] segment_seq;
      logic [15:0] payload_bytes;
      logic [31:0] random_isn;
      logic [1:0]  write_state;
      logic [31:0] write_seq;
      logic [31:0] write_ack_seq;
   } req_type;

   typedef struct packed {
      logic        verdict_drop;
      logic        send_reply;
      logic        reply_syn;
      logic        reply_ack;
      logic        reply_rst;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack_seq;
      logic [1:0]  state_after;
      logic [1:0]  reset_class;
      logic        newly_established;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request, issue table read
      logic commit;  // write back record, load result register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_full;
   } dp_status_type;

   typedef logic [SLOT_W-1:0] slot_map_type [256];

   // slot field reduced modulo SLOTS, built at elaboration
   function automatic slot_map_type build_slot_map();
      slot_map_type m;
      for (int i = 0; i < 256; i++) begin
         m[i] = SLOT_W'(i % SLOTS);
      end
      return m;
   endfunction

   localparam slot_map_type SLOT_MAP = build_slot_map();

endpackage

>>> rtl/tcp_handshake_conn_table.sv
// Top level of the TCP handshake connection table.
//
//   group  role    tdata fields                                         tuser
//   req_   input   segment or slot write request                        op
//   rsp_   output  verdict, control reply, new state, reset class       -
//
// For each request the slot record is read from the table RAM into a register
// when the request is taken, then stepped and written back in the update step,
// so a request to the same slot always sees the previous write. req_tready is
// high only between requests. A stalled result holds the update step until the
// result register frees up. Reset clears the per-slot valid bits at once; there
// is no clearing pass.
module tcp_handshake_conn_table
   import tcp_hs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] slot, [8] flag_syn, [9] flag_ack, [10] flag_rst, [42:11] segment_seq,
   // [58:43] payload_bytes, [90:59] random_isn, [92:91] write_state,
   // [124:93] write_seq, [156:125] write_ack_seq, [159:157] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] op
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] verdict_drop, [1] send_reply, [2] reply_syn, [3] reply_ack, [4] reply_rst,
   // [36:5] reply_seq, [68:37] reply_ack_seq, [70:69] state_after,
   // [72:71] reset_class, [73] newly_established, [79:74] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   req_type       req;
   rsp_type       rsp;
   dp_cmd_type    cmd;
   dp_status_type status;

   always_comb begin
      req.op            = req_tuser;
      req.slot          = req_tdata[7:0];
      req.flag_syn      = req_tdata[8];
      req.flag_ack      = req_tdata[9];
      req.flag_rst      = req_tdata[10];
      req.segment_seq   = req_tdata[42:11];
      req.payload_bytes = req_tdata[58:43];
      req.random_isn    = req_tdata[90:59];
      req.write_state   = req_tdata[92:91];
      req.write_seq     = req_tdata[124:93];
      req.write_ack_seq = req_tdata[156:125];
   end

   assign rsp_tdata = {6'd0, rsp.newly_established, rsp.reset_class, rsp.state_after,
                       rsp.reply_ack_seq, rsp.reply_seq, rsp.reply_rst, rsp.reply_ack,
                       rsp.reply_syn, rsp.send_reply, rsp.verdict_drop};

   tcp_hs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   tcp_hs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

endmodule

>>> rtl/tcp_hs_ctrl.sv
// Controller sequencing the read and update steps of one request.
module tcp_hs_ctrl
   import tcp_hs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // result register must be free, or emptying this cycle
            if (!status.out_full || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/tcp_hs_dpath.sv
// Datapath: slot table RAM, valid bits, handshake step logic and result register.
module tcp_hs_dpath
   import tcp_hs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp
);

   rec_type           rec_mem [SLOTS];
   logic [SLOTS-1:0]  valid_ff;
   req_type           req_ff;
   logic [SLOT_W-1:0] idx_ff;
   rec_type           rd_ff;
   rsp_type           rsp_ff;
   logic              out_full_ff;

   rec_type           cur;
   logic              cur_valid;
   rec_type           nrec;
   logic              nvalid;
   rsp_type           res;
   logic [31:0]       nack;
   hs_state_type      st;

   // request capture and table read
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         idx_ff <= SLOT_MAP[req.slot];
         rd_ff  <= rec_mem[SLOT_MAP[req.slot]];
      end
   end

   assign cur_valid = valid_ff[idx_ff];
   assign cur       = cur_valid ? rd_ff : '0;
   assign st        = hs_state_type'(cur.state);
   assign nack      = req_ff.segment_seq + 32'(req_ff.payload_bytes)
                      + 32'(req_ff.flag_syn);

   always_comb begin
      logic bad;
      bad    = 1'b0;
      res    = '0;
      nrec   = cur;
      nvalid = 1'b1;
      if (req_ff.op == OP_WRITE) begin
         nrec.state        = req_ff.write_state;
         nrec.local_seq    = req_ff.write_seq;
         nrec.peer_ack_seq = req_ff.write_ack_seq;
      end else if (req_ff.flag_rst) begin
         res.verdict_drop = 1'b1;
         if (cur_valid) begin
            case (st)
               CS_ESTAB:                res.reset_class = RC_ESTAB;
               CS_SYN_SENT, CS_SYN_RECV: res.reset_class = RC_HANDSHAKE;
               default:                 res.reset_class = RC_NONE;
            endcase
         end
         nrec   = '0;
         nvalid = 1'b0;
      end else begin
         if ((st inside {CS_IDLE, CS_SYN_RECV, CS_ESTAB})
             && req_ff.flag_syn && !req_ff.flag_ack) begin
            res.verdict_drop   = 1'b1;
            res.send_reply     = 1'b1;
            res.reply_syn      = 1'b1;
            res.reply_ack      = 1'b1;
            res.reply_seq      = req_ff.random_isn;
            res.reply_ack_seq  = nack;
            nrec.state         = CS_SYN_RECV;
            nrec.local_seq     = req_ff.random_isn + 32'd1;
            nrec.peer_ack_seq  = nack;
         end else if (st == CS_SYN_RECV && !req_ff.flag_syn && req_ff.flag_ack) begin
            res.verdict_drop      = 1'b1;
            res.newly_established = 1'b1;
            nrec.state            = CS_ESTAB;
            nrec.peer_ack_seq     = nack;
         end else if (st == CS_SYN_SENT && req_ff.flag_syn) begin
            // SYN-ACK completes; bare SYN is a simultaneous open
            res.verdict_drop      = 1'b1;
            res.send_reply        = 1'b1;
            res.reply_ack         = 1'b1;
            res.newly_established = req_ff.flag_ack;
            res.reply_seq         = cur.local_seq;
            res.reply_ack_seq     = nack;
            nrec.state            = req_ff.flag_ack ? CS_ESTAB : CS_SYN_RECV;
            nrec.peer_ack_seq     = nack;
         end else if (st == CS_ESTAB && !req_ff.flag_syn && req_ff.flag_ack) begin
            nrec.peer_ack_seq = cur.peer_ack_seq + 32'(req_ff.payload_bytes);
         end else begin
            bad = 1'b1;
         end
         if (bad) begin
            res.verdict_drop  = 1'b1;
            res.send_reply    = 1'b1;
            res.reply_ack     = 1'b1;
            res.reply_rst     = 1'b1;
            res.reply_ack_seq = nack;
            nrec              = '0;
            nvalid            = 1'b0;
         end
      end
      res.state_after = nrec.state;
   end

   // table write-back
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rec_mem[idx_ff] <= nrec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         out_full_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            valid_ff[idx_ff] <= nvalid;
            out_full_ff      <= 1'b1;
         end else if (rsp_ready) begin
            out_full_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= res;
      end
   end

   assign status.out_full = out_full_ff;
   assign rsp_valid       = out_full_ff;
   assign rsp             = rsp_ff;

endmodule

>>> rtl/tcp_hs_checker.sv
// Port-level checker for the connection table, bound to the top level.
`include "tcp_handshake_conn_table_macros.svh"

module tcp_hs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   // a stalled result keeps its bits
   `TCP_HS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")

   // one request in flight at a time
   `TCP_HS_ASSERT_NEXT(a_one_inflight, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")

   // without a reply every reply field is zero
   `TCP_HS_ASSERT_NOW(a_no_reply_zero, clock, reset, rsp_tvalid && !rsp_tdata[1], rsp_tdata[68:2] == 67'd0, "reply fields set without reply")

   // RST-ACK reply: dropped, slot back to idle, zero sequence
   `TCP_HS_ASSERT_NOW(a_rst_reply, clock, reset, rsp_tvalid && rsp_tdata[4], rsp_tdata[0] && rsp_tdata[1] && rsp_tdata[70:69] == 2'd0 && rsp_tdata[36:5] == 32'd0, "bad RST-ACK result")

   // reset classification only on a silently dropped RST
   `TCP_HS_ASSERT_NOW(a_reset_class, clock, reset, rsp_tvalid && rsp_tdata[72:71] != 2'd0, rsp_tdata[0] && !rsp_tdata[1] && rsp_tdata[72:71] != 2'd3 && rsp_tdata[70:69] == 2'd0, "bad reset class")

endmodule

bind tcp_handshake_conn_table tcp_hs_checker u_tcp_hs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> dv/tcp_handshake_conn_table_tb.sv
// Self-checking testbench for the TCP handshake connection table: directed and random traffic.
`timescale 1ns / 100ps

module tcp_handshake_conn_table_tb;
   import tcp_hs_pkg::*;

   localparam int QUIET_LIMIT = 5000;   // cycles with no transfer before giving up
   localparam int DRAIN_CYCLES = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // own copy of the connection records
   logic           conn_valid [SLOTS];
   hs_state_type   conn_st [SLOTS];
   logic [31:0]    conn_lseq [SLOTS];
   logic [31:0]    conn_peer_ack [SLOTS];

   rsp_type pending_verdicts [$];
   int      items_sent = 0;
   int      mismatches = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_request = 0;
   int      hold_left = 0;
   int      quiet_cycles = 0;

   tcp_handshake_conn_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_conn(int s);
      conn_valid[s]    = 1'b0;
      conn_st[s]       = CS_IDLE;
      conn_lseq[s]     = '0;
      conn_peer_ack[s] = '0;
   endfunction

   // steps one record and returns the result the block must give
   function automatic rsp_type step_conn_record(req_type r);
      rsp_type        e;
      int             s;
      logic [31:0]    nack;
      hs_state_type   st;
      logic           bad;
      e    = '0;
      bad  = 1'b0;
      s    = int'(r.slot) % SLOTS;
      nack = r.segment_seq + 32'(r.payload_bytes) + 32'(r.flag_syn);
      if (r.op == OP_WRITE) begin
         conn_valid[s]    = 1'b1;
         conn_st[s]       = hs_state_type'(r.write_state);
         conn_lseq[s]     = r.write_seq;
         conn_peer_ack[s] = r.write_ack_seq;
      end else if (r.flag_rst) begin
         e.verdict_drop = 1'b1;
         if (conn_valid[s]) begin
            case (conn_st[s])
               CS_ESTAB: e.reset_class = RC_ESTAB;
               CS_IDLE:  e.reset_class = RC_NONE;
               default:  e.reset_class = RC_HANDSHAKE;
            endcase
            clear_conn(s);
         end
      end else begin
         if (!conn_valid[s]) begin
            clear_conn(s);
            conn_valid[s] = 1'b1;
         end
         st = conn_st[s];
         if (st != CS_SYN_SENT && r.flag_syn && !r.flag_ack) begin
            e.verdict_drop  = 1'b1;
            e.send_reply    = 1'b1;
            e.reply_syn     = 1'b1;
            e.reply_ack     = 1'b1;
            e.reply_seq     = r.random_isn;
            e.reply_ack_seq = nack;
            conn_st[s]       = CS_SYN_RECV;
            conn_lseq[s]     = r.random_isn + 32'd1;
            conn_peer_ack[s] = nack;
         end else if (st == CS_SYN_RECV && !r.flag_syn && r.flag_ack) begin
            e.verdict_drop      = 1'b1;
            e.newly_established = 1'b1;
            conn_peer_ack[s]    = nack;
            conn_st[s]          = CS_ESTAB;
         end else if (st == CS_SYN_SENT && r.flag_syn) begin
            // SYN-ACK finishes the open, a bare SYN means both sides opened
            e.verdict_drop      = 1'b1;
            e.send_reply        = 1'b1;
            e.reply_ack         = 1'b1;
            e.newly_established = r.flag_ack;
            conn_st[s]          = r.flag_ack ? CS_ESTAB : CS_SYN_RECV;
            e.reply_seq         = conn_lseq[s];
            e.reply_ack_seq     = nack;
            conn_peer_ack[s]    = nack;
         end else if (st == CS_ESTAB && !r.flag_syn && r.flag_ack) begin
            conn_peer_ack[s] = conn_peer_ack[s] + 32'(r.payload_bytes);
         end else begin
            bad = 1'b1;
         end
         if (bad) begin
            e.verdict_drop  = 1'b1;
            e.send_reply    = 1'b1;
            e.reply_ack     = 1'b1;
            e.reply_rst     = 1'b1;
            e.reply_seq     = '0;
            e.reply_ack_seq = nack;
            clear_conn(s);
         end
      end
      e.state_after = conn_st[s];
      return e;
   endfunction

   function automatic req_type segment_req(logic [7:0] slot, logic syn, logic ack, logic rst,
                                           logic [31:0] seq, logic [15:0] plen,
                                           logic [31:0] isn);
      req_type r;
      r.op            = OP_SEGMENT;
      r.slot          = slot;
      r.flag_syn      = syn;
      r.flag_ack      = ack;
      r.flag_rst      = rst;
      r.segment_seq   = seq;
      r.payload_bytes = plen;
      r.random_isn    = isn;
      r.write_state   = 2'($urandom());
      r.write_seq     = $urandom();
      r.write_ack_seq = $urandom();
      return r;
   endfunction

   // segment fields carry noise: a write must ignore them
   function automatic req_type slot_write_req(logic [7:0] slot, hs_state_type st,
                                              logic [31:0] lseq, logic [31:0] pack);
      req_type r;
      r = segment_req(slot, 1'($urandom()), 1'($urandom()), 1'($urandom()), $urandom(),
                      16'($urandom()), $urandom());
      r.op            = OP_WRITE;
      r.write_state   = st;
      r.write_seq     = lseq;
      r.write_ack_seq = pack;
      return r;
   endfunction

   // a few hot slots give back-to-back hits on the same record
   function automatic logic [7:0] pick_slot();
      return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom());
   endfunction

   function automatic logic [15:0] pick_len();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1460));
   endfunction

   task automatic send_item(req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {3'b000, r.write_ack_seq, r.write_seq, r.write_state, r.random_isn,
                     r.payload_bytes, r.segment_seq, r.flag_rst, r.flag_ack, r.flag_syn,
                     r.slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_verdicts.push_back(step_conn_record(r));
      items_sent++;
   endtask

   task automatic test_slot_writes();
      send_item(slot_write_req(8'd255, CS_ESTAB, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(slot_write_req(8'd0, CS_IDLE, 32'h0, 32'h0));
   endtask

   task automatic test_passive_open();
      // fresh slot, sequence and ISN both wrap
      send_item(segment_req(8'd1, 1, 0, 0, 32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF));
      send_item(segment_req(8'd1, 0, 1, 0, 32'h0000_0000, 16'hFFFF, $urandom()));
      send_item(segment_req(8'd1, 0, 1, 0, $urandom(), 16'd1000, $urandom()));
      // SYN on an established record restarts the handshake
      send_item(segment_req(8'd1, 1, 0, 0, $urandom(), 16'd12, $urandom()));
   endtask

   task automatic test_active_open();
      send_item(slot_write_req(8'd2, CS_SYN_SENT, 32'h0000_1234, 32'h0));
      send_item(segment_req(8'd2, 1, 1, 0, $urandom(), 16'd0, $urandom()));
      send_item(slot_write_req(8'd3, CS_SYN_SENT, $urandom(), $urandom()));
      send_item(segment_req(8'd3, 1, 0, 0, $urandom(), 16'd0, $urandom()));
      send_item(segment_req(8'd3, 0, 1, 0, $urandom(), 16'd0, $urandom()));
   endtask

   task automatic test_rst_classes();
      send_item(segment_req(8'd2, 0, 0, 1, $urandom(), 16'd0, $urandom()));
      send_item(slot_write_req(8'd4, CS_SYN_RECV, $urandom(), $urandom()));
      send_item(segment_req(8'd4, 0, 1, 1, $urandom(), 16'd5, $urandom()));
      send_item(slot_write_req(8'd5, CS_SYN_SENT, $urandom(), $urandom()));
      send_item(segment_req(8'd5, 1, 0, 1, $urandom(), 16'd0, $urandom()));
      // never-written record and a valid idle one both give no class
      send_item(segment_req(8'd6, 0, 0, 1, $urandom(), 16'd0, $urandom()));
      send_item(segment_req(8'd0, 0, 0, 1, $urandom(), 16'd0, $urandom()));
      send_item(segment_req(8'd255, 1, 1, 1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
   endtask

   task automatic test_bad_segments();
      send_item(segment_req(8'd7, 0, 1, 0, $urandom(), 16'd40, $urandom()));
      send_item(segment_req(8'd7, 1, 1, 0, $urandom(), 16'd0, $urandom()));
      send_item(segment_req(8'd1, 0, 0, 0, $urandom(), 16'd3, $urandom()));
      send_item(slot_write_req(8'd8, CS_SYN_SENT, $urandom(), $urandom()));
      send_item(segment_req(8'd8, 0, 1, 0, $urandom(), 16'd0, $urandom()));
   endtask

   task automatic random_traffic(int count);
      int         stop_at;
      int         n_data;
      logic [7:0] s;
      req_type    r;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         s = pick_slot();
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               send_item(segment_req(s, 1, 0, 0, $urandom(), pick_len(), $urandom()));
               send_item(segment_req(s, 0, 1, 0, $urandom(), pick_len(), $urandom()));
               n_data = $urandom_range(0, 4);
               repeat (n_data)
                  send_item(segment_req(s, 0, 1, 0, $urandom(), pick_len(), $urandom()));
               case ($urandom_range(0, 4))
                  0: send_item(segment_req(s, 1'($urandom()), 1'($urandom()), 1,
                                           $urandom(), pick_len(), $urandom()));
                  1: send_item(segment_req(s, 0, 0, 0, $urandom(), pick_len(), $urandom()));
                  default: ;
               endcase
            end
            4, 5: begin
               send_item(slot_write_req(s, CS_SYN_SENT, $urandom(), $urandom()));
               if ($urandom_range(0, 9) < 7) begin
                  send_item(segment_req(s, 1, 1, 0, $urandom(), pick_len(), $urandom()));
               end else begin
                  send_item(segment_req(s, 1, 0, 0, $urandom(), pick_len(), $urandom()));
                  send_item(segment_req(s, 0, 1, 0, $urandom(), pick_len(), $urandom()));
               end
               send_item(segment_req(s, 0, 1, 0, $urandom(), pick_len(), $urandom()));
            end
            6: begin
               send_item(slot_write_req(s, hs_state_type'($urandom_range(0, 3)),
                                        $urandom(), $urandom()));
               send_item(segment_req(s, 1'($urandom()), 1'($urandom()), 1'($urandom()),
                                     $urandom(), pick_len(), $urandom()));
            end
            default: begin
               repeat ($urandom_range(1, 3)) begin
                  r = segment_req(pick_slot(), 1'($urandom()), 1'($urandom()),
                                  1'($urandom()), $urandom(), 16'($urandom()), $urandom());
                  r.op = 1'($urandom());
                  send_item(r);
               end
            end
         endcase
      end
   endtask

   // result side held off long enough for the request side to back up
   task automatic test_backpressure();
      hold_request = 400;
      random_traffic(40);
   endtask

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.verdict_drop      = rsp_tdata[0];
         got.send_reply        = rsp_tdata[1];
         got.reply_syn         = rsp_tdata[2];
         got.reply_ack         = rsp_tdata[3];
         got.reply_rst         = rsp_tdata[4];
         got.reply_seq         = rsp_tdata[36:5];
         got.reply_ack_seq     = rsp_tdata[68:37];
         got.state_after       = rsp_tdata[70:69];
         got.reset_class       = rsp_tdata[72:71];
         got.newly_established = rsp_tdata[73];
         if (pending_verdicts.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("verdict_drop", 32'(want.verdict_drop), 32'(got.verdict_drop));
            check_field("send_reply", 32'(want.send_reply), 32'(got.send_reply));
            check_field("reply_syn", 32'(want.reply_syn), 32'(got.reply_syn));
            check_field("reply_ack", 32'(want.reply_ack), 32'(got.reply_ack));
            check_field("reply_rst", 32'(want.reply_rst), 32'(got.reply_rst));
            check_field("reply_seq", want.reply_seq, got.reply_seq);
            check_field("reply_ack_seq", want.reply_ack_seq, got.reply_ack_seq);
            check_field("state_after", 32'(want.state_after), 32'(got.state_after));
            check_field("reset_class", 32'(want.reset_class), 32'(got.reset_class));
            check_field("newly_established", 32'(want.newly_established),
                        32'(got.newly_established));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) clear_conn(i);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 19;
      recv_idle_pct = 69;
      test_slot_writes();
      test_passive_open();
      test_active_open();
      test_rst_classes();
      test_bad_segments();
      random_traffic(270);

      send_idle_pct = 69;
      recv_idle_pct = 19;
      random_traffic(270);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      random_traffic(250);

      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tcp_hs_pkg.sv
rtl/tcp_hs_ctrl.sv
rtl/tcp_hs_dpath.sv
rtl/tcp_handshake_conn_table.sv
rtl/tcp_hs_checker.sv
dv/tcp_handshake_conn_table_tb.sv
